// ----- hdl/ldser_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldser_pkg
// Types and constants for the LED pixel dither serializer: transaction
// structs for both channels, operation codes and payload constants.
// ----------------------------------------------------------------------------
package ldser_pkg;

    localparam logic OP_SET_COLOUR = 1'b0;
    localparam logic OP_TICK       = 1'b1;

    localparam logic [15:0] PAYLOAD_MARK = 16'h8000;
    localparam logic [7:0]  CHAN_MAX     = 8'hFF;
    localparam logic [3:0]  BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic       op;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } ldser_req_t;

    typedef struct packed {
        logic       data_bit;
        logic [5:0] frame_bit_index;
    } ldser_rsp_t;

endpackage

// ----- hdl/led_pixel_dither_serializer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_pixel_dither_serializer
// Serializes a repeating LED pixel frame, one data bit per tick transaction,
// with a 5-5-5 payload word (green, blue, red) rebuilt once per frame under temporal dither.
// ----------------------------------------------------------------------------
// A transaction on req either stores a new colour (op clear) or requests one
// serial bit (op set). Each tick returns one rsp transaction with the data bit
// and its position in the frame; colour writes return nothing and take effect
// at the next payload rebuild, which happens when frame byte 1 is loaded and
// is sent from the following frame on. One transaction is taken per clock: a
// request passes an input register and then the output register, where the
// result is held; the only stall comes from rsp_ready held low with a result
// waiting in the output register.
// ----------------------------------------------------------------------------
module led_pixel_dither_serializer
    import ldser_pkg::*;
#(
    parameter int FRAME_BYTES = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  ldser_req_t req,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output ldser_rsp_t rsp
);

    localparam int SW = $clog2(FRAME_BYTES);
    localparam logic [SW-1:0] LAST_SLOT = SW'(FRAME_BYTES - 1);
    localparam logic [SW-1:0] SLOT_ONE  = SW'(1);
    localparam logic [SW-1:0] SLOT_ZERO = SW'(0);

    logic            in_valid_reg;
    ldser_req_t      in_item_reg;
    logic            out_valid_reg;
    ldser_rsp_t      out_item_reg;

    logic [7:0]      red_reg, green_reg, blue_reg;
    logic [3:0]      dither_phase_reg;
    logic [15:0]     payload_word_reg;
    logic [7:0]      shift_byte_reg;
    logic [SW-1:0]   next_slot_reg;
    logic [3:0]      bits_left_reg;

    logic [3:0]      dither_phase_next;
    logic [15:0]     payload_word_next;
    logic [7:0]      shift_byte_next;
    logic [SW-1:0]   next_slot_next;
    logic [3:0]      bits_left_next;
    ldser_rsp_t      out_item_next;

    logic            advance;
    logic            is_tick;
    logic [2:0]      bit_sel;
    logic [SW-1:0]   cur_slot;
    logic [SW-1:0]   slot_inc;
    logic [SW+2:0]   pos_full;
    logic [4:0]      offset;

    // clamp channel plus offset to 0..255 and keep the top 5 bits
    function automatic logic [4:0] chan5(input logic [7:0] v, input logic [4:0] d);
        logic [9:0] s;
        begin
            s = {2'b00, v} + {{5{d[4]}}, d};
            if (s[9])
            begin
                chan5 = 5'd0;
            end
            else if (s[8])
            begin
                chan5 = CHAN_MAX[7:3];
            end
            else
            begin
                chan5 = s[7:3];
            end
        end
    endfunction

    assign advance   = in_valid_reg && (!out_valid_reg || rsp_ready);
    assign req_ready = !in_valid_reg || advance;
    assign is_tick   = (in_item_reg.op == OP_TICK);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_item_reg;

    assign bit_sel  = 3'(bits_left_reg - 4'd1);
    assign cur_slot = (next_slot_reg == SLOT_ZERO) ? LAST_SLOT : next_slot_reg - SLOT_ONE;
    assign slot_inc = (next_slot_reg == LAST_SLOT) ? SLOT_ZERO : next_slot_reg + SLOT_ONE;
    assign pos_full = {cur_slot, 3'd7 - bit_sel};

    // dither counter step and offset
    always_comb
    begin
        if (dither_phase_reg == 4'd7 || dither_phase_reg == 4'b1000)
        begin
            dither_phase_next = 4'd0;
        end
        else if (dither_phase_reg[3])
        begin
            dither_phase_next = 4'd0 - dither_phase_reg;
        end
        else
        begin
            dither_phase_next = ~dither_phase_reg;
        end
        offset = {dither_phase_next[3], dither_phase_next} + 5'd1;
    end

    always_comb
    begin
        payload_word_next = PAYLOAD_MARK | {1'b0, chan5(green_reg, offset),
                            chan5(blue_reg, offset), chan5(red_reg, offset)};
        out_item_next.data_bit        = shift_byte_reg[bit_sel];
        out_item_next.frame_bit_index = 6'(pos_full);
        case (next_slot_reg)
            SLOT_ZERO: shift_byte_next = payload_word_reg[15:8];
            SLOT_ONE:  shift_byte_next = payload_word_reg[7:0];
            default:   shift_byte_next = 8'd0;
        endcase
        next_slot_next = slot_inc;
        bits_left_next = (bit_sel == 3'd0) ? BITS_PER_BYTE : {1'b0, bit_sel};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            red_reg          <= 8'd0;
            green_reg        <= 8'd0;
            blue_reg         <= 8'd0;
            dither_phase_reg <= 4'd0;
            payload_word_reg <= 16'd0;
            shift_byte_reg   <= 8'd0;
            next_slot_reg    <= SLOT_ONE;
            bits_left_reg    <= BITS_PER_BYTE;
        end
        else
        begin
            if (req_ready)
            begin
                in_valid_reg <= req_valid;
            end
            if (advance && is_tick)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (advance && !is_tick)
            begin
                red_reg   <= in_item_reg.red;
                green_reg <= in_item_reg.green;
                blue_reg  <= in_item_reg.blue;
            end
            if (advance && is_tick)
            begin
                bits_left_reg <= bits_left_next;
                if (bit_sel == 3'd0)
                begin
                    shift_byte_reg <= shift_byte_next;
                    next_slot_reg  <= next_slot_next;
                    if (next_slot_reg == SLOT_ONE)
                    begin
                        payload_word_reg <= payload_word_next;
                        dither_phase_reg <= dither_phase_next;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            in_item_reg <= req;
        end
        if (advance && is_tick)
        begin
            out_item_reg <= out_item_next;
        end
    end

`ifndef SYNTHESIS
    a_bits_left_range: assert property (@(posedge clk) disable iff (!rst_n)
        bits_left_reg >= 4'd1 && bits_left_reg <= BITS_PER_BYTE)
        else $error("bits_left out of range");

    a_dither_range: assert property (@(posedge clk) disable iff (!rst_n)
        dither_phase_reg != 4'b1000)
        else $error("dither phase reached minus eight");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(next_slot_reg) < FRAME_BYTES)
        else $error("frame slot out of range");

    a_byte_reload: assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_tick && bits_left_reg == 4'd1 |=> bits_left_reg == BITS_PER_BYTE)
        else $error("bit counter not reloaded after last bit");

    a_colour_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !is_tick && !out_valid_reg |=> !out_valid_reg)
        else $error("colour write produced a result");
`endif

endmodule

// ----- test/ldser_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldser_checker
// Watches both channels of the LED pixel dither serializer, keeps its own
// copy of the colour, dither counter, payload word and shift state, predicts
// the serial bit and frame position of every tick transaction, and compares
// each returned result in order against the oldest prediction.
// ----------------------------------------------------------------------------
module ldser_checker
    import ldser_pkg::*;
#(
    parameter int FRAME_BYTES = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic       req_ready,
    input  ldser_req_t req,
    input  logic       rsp_valid,
    input  logic       rsp_ready,
    input  ldser_rsp_t rsp,
    output int         errors,
    output int         pending,
    output int         colour_writes,
    output int         ticks_checked,
    output int         payload_rebuilds
);

    logic [7:0]        cur_red;
    logic [7:0]        cur_green;
    logic [7:0]        cur_blue;
    logic signed [3:0] dither_count;
    logic [15:0]       pixel_word;
    logic [7:0]        out_byte;
    int unsigned       byte_slot;
    int unsigned       bits_to_go;
    ldser_rsp_t        expected_bits[$];
    ldser_rsp_t        want;
    ldser_rsp_t        got;

    function automatic logic [7:0] clamp_level(input logic [7:0] level, input int offset);
        int sum;
        sum = int'(level) + offset;
        if (sum < 0)
            return '0;
        if (sum > int'(CHAN_MAX))
            return CHAN_MAX;
        return sum[7:0];
    endfunction

    task automatic rebuild_pixel_word();
        int         c;
        int         offset;
        logic [7:0] g_lvl;
        logic [7:0] b_lvl;
        logic [7:0] r_lvl;
        c = dither_count;
        if (c < 0)
            c = c - 1;
        c = (~c) % 8;
        dither_count = c[3:0];
        offset = c + 1;
        g_lvl = clamp_level(cur_green, offset);
        b_lvl = clamp_level(cur_blue, offset);
        r_lvl = clamp_level(cur_red, offset);
        pixel_word = PAYLOAD_MARK;
        pixel_word[14:10] = g_lvl[7:3];
        pixel_word[9:5] = b_lvl[7:3];
        pixel_word[4:0] = r_lvl[7:3];
        payload_rebuilds++;
    endtask

    task automatic shift_out_bit(output ldser_rsp_t bit_out);
        int unsigned slot_now;
        bits_to_go = (bits_to_go - 1) & 32'd7;
        bit_out.data_bit = out_byte[bits_to_go];
        slot_now = (byte_slot + FRAME_BYTES - 1) % FRAME_BYTES;
        bit_out.frame_bit_index = 6'(slot_now * 8 + 7 - bits_to_go);
        if (bits_to_go == 0)
        begin
            case (byte_slot)
                0:       out_byte = pixel_word[15:8];
                1:       out_byte = pixel_word[7:0];
                default: out_byte = 8'h00;
            endcase
            byte_slot = (byte_slot + 1) % FRAME_BYTES;
            // payload refresh when frame byte 1 goes into the shifter
            if (byte_slot == 2)
                rebuild_pixel_word();
            bits_to_go = BITS_PER_BYTE;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_red = '0;
            cur_green = '0;
            cur_blue = '0;
            dither_count = '0;
            pixel_word = '0;
            out_byte = '0;
            byte_slot = 1;
            bits_to_go = BITS_PER_BYTE;
            expected_bits.delete();
            errors = 0;
            colour_writes = 0;
            ticks_checked = 0;
            payload_rebuilds = 0;
            pending <= 0;
        end
        else
        begin
            if (req_valid === 1'b1 && req_ready === 1'b1)
            begin
                if (req.op == OP_SET_COLOUR)
                begin
                    cur_red = req.red;
                    cur_green = req.green;
                    cur_blue = req.blue;
                    colour_writes++;
                end
                else
                begin
                    shift_out_bit(want);
                    expected_bits.push_back(want);
                end
            end
            if (rsp_valid === 1'b1 && rsp_ready === 1'b1)
            begin
                got = rsp;
                if (expected_bits.size() == 0)
                begin
                    $error("unexpected transaction: data_bit %0d, frame_bit_index %0d",
                           got.data_bit, got.frame_bit_index);
                    errors++;
                end
                else
                begin
                    want = expected_bits.pop_front();
                    if (got.data_bit !== want.data_bit)
                    begin
                        $error("data_bit: expected %0d, actual %0d",
                               want.data_bit, got.data_bit);
                        errors++;
                    end
                    if (got.frame_bit_index !== want.frame_bit_index)
                    begin
                        $error("frame_bit_index: expected %0d, actual %0d",
                               want.frame_bit_index, got.frame_bit_index);
                        errors++;
                    end
                    ticks_checked++;
                end
            end
            pending <= expected_bits.size();
        end
    end

endmodule

// ----- test/tb_led_pixel_dither_serializer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_pixel_dither_serializer
// Drives colour writes and bit ticks into the LED pixel dither serializer
// with random gaps and output stalls, including one long output hold, and
// reports the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module tb_led_pixel_dither_serializer;
    import ldser_pkg::*;

    localparam int FRAME_BYTES  = 8;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 1700;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int SQUEEZE_AT   = 600;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_ready;
    ldser_req_t req = '0;
    logic       rsp_valid;
    logic       rsp_ready = 1'b0;
    ldser_rsp_t rsp;
    logic       squeeze = 1'b0;
    int unsigned cycle_count = 0;
    int         errors;
    int         pending;
    int         colour_writes;
    int         ticks_checked;
    int         payload_rebuilds;

    led_pixel_dither_serializer #(
        .FRAME_BYTES(FRAME_BYTES)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    ldser_checker #(
        .FRAME_BYTES(FRAME_BYTES)
    ) CHK (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp),
        .errors(errors),
        .pending(pending),
        .colour_writes(colour_writes),
        .ticks_checked(ticks_checked),
        .payload_rebuilds(payload_rebuilds)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    // bias toward the clamp edges
    function automatic logic [7:0] pick_level();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'($urandom_range(0, 7));
        if (r == 1)
            return 8'($urandom_range(248, 255));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic ldser_req_t make_item(input logic op, input logic [7:0] r,
                                             input logic [7:0] g, input logic [7:0] b);
        ldser_req_t item;
        item.op = op;
        item.red = r;
        item.green = g;
        item.blue = b;
        return item;
    endfunction

    task automatic offer_request(input ldser_req_t item);
        req_valid <= 1'b1;
        req <= item;
        do
            @(posedge clk);
        while (req_ready !== 1'b1);
    endtask

    task automatic pause_sender(input int gap);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // receiver
    initial
    begin
        int gap;
        bit hold_done;
        hold_done = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(100, 250)) @(posedge clk);
            else
                repeat ($urandom_range(1, 30)) @(posedge clk);
            if (squeeze && !hold_done)
            begin
                hold_done = 1'b1;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                gap = pick_gap();
                if (gap > 0)
                begin
                    rsp_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    // sender
    initial
    begin
        ldser_req_t item;
        int         gap;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer_request(make_item(OP_SET_COLOUR, 8'h00, 8'h00, 8'h00));
        offer_request(make_item(OP_TICK, 8'hFF, 8'hFF, 8'hFF));
        offer_request(make_item(OP_SET_COLOUR, 8'hFF, 8'hFF, 8'hFF));
        for (int k = 0; k < 7; k++)
        begin
            offer_request(make_item(OP_TICK, 8'(k * 37), 8'hAA, 8'h55));
            pause_sender(k % 3);
        end
        offer_request(make_item(OP_SET_COLOUR, 8'h04, 8'hFB, 8'h02));
        for (int k = 0; k < 8; k++)
            offer_request(make_item(OP_TICK, 8'h55, 8'h00, 8'hFF));
        offer_request(make_item(OP_SET_COLOUR, 8'hFF, 8'h00, 8'hAA));
        offer_request(make_item(OP_SET_COLOUR, 8'h55, 8'hAA, 8'h80));

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == SQUEEZE_AT)
                squeeze = 1'b1;
            item.op = ($urandom_range(0, 99) < 12) ? OP_SET_COLOUR : OP_TICK;
            item.red = pick_level();
            item.green = pick_level();
            item.blue = pick_level();
            offer_request(item);
            // back-to-back windows, one of them under the long output hold
            if ((i >= SQUEEZE_AT && i < SQUEEZE_AT + 100) || (i / 150) % 5 == 4)
                gap = 0;
            else
                gap = pick_gap();
            pause_sender(gap);
        end
        req_valid <= 1'b0;

        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d colour writes and %0d serial bits over %0d payload rebuilds",
                 colour_writes, ticks_checked, payload_rebuilds);
        $display("random gaps on both channels plus one %0d-cycle output hold",
                 HOLD_CYCLES);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/ldser_pkg.sv
hdl/led_pixel_dither_serializer.sv
test/ldser_checker.sv
test/tb_led_pixel_dither_serializer.sv
